// ===== rtl/wpsg_pkg.sv =====
// ----------------------------------------------------------------------------
// Wheel setpoint package
// Shared widths, operation and register codes, item types and the Q16.16
// saturation helper for the wheel position setpoint generator.
// ----------------------------------------------------------------------------
package wpsg_pkg;

	localparam int WPSG_WHEEL_COUNT = 6;
	localparam int WPSG_QUEUE_DEPTH = 4;
	localparam int SIDE_WHEELS      = 3;
	localparam int WHEEL_W          = 3;
	localparam int DATA_W           = 32;
	localparam int CFG_W            = 31;
	localparam int CFG_IDX_W        = 3;
	localparam int FRAC_W           = 16;
	localparam int PROD_W           = 2 * DATA_W;
	localparam int QUOT_W           = PROD_W - FRAC_W;

	typedef enum logic [1:0] {
		OP_SEED = 2'd0,
		OP_SIDE = 2'd1,
		OP_TICK = 2'd2,
		OP_FEED = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_SPEED      = 3'd0,
		REG_INV_RADIUS     = 3'd1,
		REG_MAX_RATE       = 3'd2,
		REG_LOOP_PERIOD    = 3'd3,
		REG_ERROR_LIMIT    = 3'd4,
		REG_RADIUS         = 3'd5,
		REG_FEEDBACK_SCALE = 3'd6
	} reg_idx_t;

	typedef logic signed [DATA_W-1:0] q16_t;
	typedef logic [CFG_W-1:0]         ucfg_t;

	typedef struct packed {
		ucfg_t min_speed;
		ucfg_t inverse_wheel_radius;
		ucfg_t max_wheel_rate;
		ucfg_t loop_period;
		ucfg_t error_limit;
		ucfg_t wheel_radius;
		ucfg_t feedback_scale;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		min_speed:            31'd3277,
		inverse_wheel_radius: 31'd655360,
		max_wheel_rate:       31'd655360,
		loop_period:          31'd655,
		error_limit:          31'd327680,
		wheel_radius:         31'd6554,
		feedback_scale:       31'd65536
	};

	// Classified item as it waits in the queue
	typedef struct packed {
		op_t               op;
		logic [WHEEL_W-1:0] wheel;
		q16_t              speed;
		q16_t              meas;
		logic              valid;
	} item_t;

	// Result fields known once the state update is done
	typedef struct packed {
		logic [WHEEL_W-1:0] wheel;
		q16_t              target;
		q16_t              error;
		q16_t              rate;
		q16_t              actual;
		logic              data_valid;
	} result_t;

	localparam q16_t Q16_MAX = 32'sh7FFF_FFFF;
	localparam q16_t Q16_MIN = 32'sh8000_0000;

	// Clip a wide signed value to the Q16.16 range
	function automatic q16_t sat_q16(input logic signed [PROD_W-1:0] v);
		if (v > 64'sd2147483647) begin
			return Q16_MAX;
		end else if (v < -64'sd2147483648) begin
			return Q16_MIN;
		end
		return v[DATA_W-1:0];
	endfunction

	// True when a wheel number addresses storage entry idx
	function automatic logic wheel_hit(input logic [WHEEL_W-1:0] wheel, input int unsigned idx);
		return 32'(wheel) == idx;
	endfunction

endpackage

// ===== rtl/wpsg_if.sv =====
// ----------------------------------------------------------------------------
// Wheel setpoint channels
// Valid/ready channels for command items in and setpoint results out.
// ----------------------------------------------------------------------------
interface wpsg_in_if import wpsg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [1:0]               operation;
	logic                     side;
	logic signed [DATA_W-1:0] speed_command;
	logic [WHEEL_W-1:0]       wheel_index;
	logic signed [DATA_W-1:0] measured_position;
	logic                     position_valid;

	modport source (
		output valid, operation, side, speed_command, wheel_index,
		output measured_position, position_valid,
		input  ready
	);
	modport sink (
		input  valid, operation, side, speed_command, wheel_index,
		input  measured_position, position_valid,
		output ready
	);
endinterface

interface wpsg_out_if import wpsg_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [WHEEL_W-1:0]       wheel_out;
	logic signed [DATA_W-1:0] target_position;
	logic signed [DATA_W-1:0] position_error;
	logic signed [DATA_W-1:0] wheel_rate;
	logic signed [DATA_W-1:0] target_speed;
	logic signed [DATA_W-1:0] actual_speed;
	logic                     data_valid;

	modport source (
		output valid, wheel_out, target_position, position_error, wheel_rate,
		output target_speed, actual_speed, data_valid,
		input  ready
	);
	modport sink (
		input  valid, wheel_out, target_position, position_error, wheel_rate,
		input  target_speed, actual_speed, data_valid,
		output ready
	);
endinterface

// ===== rtl/wpsg_front.sv =====
// ----------------------------------------------------------------------------
// Wheel setpoint front end
// Accepts command items, resolves the addressed wheel and drops items that
// name a wheel that does not exist.
// ----------------------------------------------------------------------------
module wpsg_front import wpsg_pkg::*; #(
	parameter int WHEEL_COUNT = WPSG_WHEEL_COUNT
) (
	wpsg_in_if.sink in_ch,
	input  logic    q_full,
	output logic    push,
	output item_t   push_item
);

	op_t  op;
	logic accept;
	logic in_range;

	assign op       = op_t'(in_ch.operation);
	assign in_ch.ready = !q_full;
	assign accept   = in_ch.valid && in_ch.ready;
	assign in_range = 32'(in_ch.wheel_index) < WHEEL_COUNT;

	// Side commands address the first wheel of their side
	always_comb begin
		push_item.op    = op;
		push_item.speed = in_ch.speed_command;
		push_item.meas  = in_ch.measured_position;
		push_item.valid = in_ch.position_valid;
		if (op == OP_SIDE) begin
			push_item.wheel = in_ch.side ? WHEEL_W'(SIDE_WHEELS) : '0;
		end else begin
			push_item.wheel = in_ch.wheel_index;
		end
	end

	// Drop wheel operations outside the wheel set: they give no result
	assign push = accept && (op == OP_SIDE || in_range);

endmodule

// ===== rtl/wpsg_queue.sv =====
// ----------------------------------------------------------------------------
// Wheel setpoint item queue
// Short first-in first-out buffer between the front end and the execute
// pipeline.
// ----------------------------------------------------------------------------
module wpsg_queue import wpsg_pkg::*; #(
	parameter int DEPTH = WPSG_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output item_t head_item
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
		return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	assign full       = count_q == CNT_W'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = slot_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store pushed items
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== rtl/wpsg_back.sv =====
// ----------------------------------------------------------------------------
// Wheel setpoint execute pipeline
// Holds per-wheel rate, target and last position, and carries items out in
// three stages: multiply, state update, reported speed, then the output
// register.
// ----------------------------------------------------------------------------
module wpsg_back import wpsg_pkg::*; #(
	parameter int WHEEL_COUNT = WPSG_WHEEL_COUNT
) (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  logic         head_valid,
	input  item_t        head_item,
	output logic         pop,
	wpsg_out_if.source   out_ch
);

	// Per-wheel state
	q16_t rate_q   [WHEEL_COUNT];
	q16_t target_q [WHEEL_COUNT];
	q16_t last_q   [WHEEL_COUNT];

	// Stage registers
	logic                     valid_s2;
	item_t                    item_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     live_s2;
	logic                     valid_s3;
	result_t                  res_s3;
	logic                     out_valid_q;
	result_t                  out_res_q;
	q16_t                     out_speed_q;

	// Stage 1 signals
	q16_t                     rate_rd1;
	q16_t                     last_rd1;
	logic signed [DATA_W:0]   diff1;
	logic signed [DATA_W:0]   mul_a1;
	ucfg_t                    mul_b1;
	logic signed [PROD_W:0]   prod1;
	logic [DATA_W-1:0]        mag1;
	logic                     live1;
	logic [WHEEL_W:0]         side_off1;
	logic                     hazard1;

	// Stage 2 signals
	logic signed [QUOT_W-1:0] quot2;
	q16_t                     sat2;
	logic signed [QUOT_W-1:0] rlim2;
	logic signed [QUOT_W-1:0] clamp2;
	q16_t                     side_rate2;
	q16_t                     rate_rd2;
	q16_t                     tgt_rd2;
	q16_t                     last_rd2;
	q16_t                     pos2;
	q16_t                     seed2;
	q16_t                     t1_2;
	logic signed [PROD_W-1:0] elim2;
	logic signed [PROD_W-1:0] hi2;
	logic signed [PROD_W-1:0] lo2;
	q16_t                     elim_q2;
	logic                     clip_hi2;
	logic                     clip_lo2;
	q16_t                     tick_tgt2;
	q16_t                     tick_err2;
	q16_t                     new_tgt2;
	q16_t                     new_last2;
	logic [WHEEL_COUNT-1:0]   side_hit2;
	result_t                  res2;

	// Stage 3 signals
	logic signed [PROD_W-1:0] prod3;
	logic signed [QUOT_W-1:0] quot3;
	q16_t                     speed3;

	// Handshake chain
	logic out_free;
	logic s3_free;
	logic s3_move;
	logic s2_free;
	logic s2_move;

	assign out_free = !out_valid_q || out_ch.ready;
	assign s3_move  = valid_s3 && out_free;
	assign s3_free  = !valid_s3 || out_free;
	assign s2_move  = valid_s2 && s3_free;
	assign s2_free  = !valid_s2 || s3_free;
	assign pop      = head_valid && s2_free && !hazard1;

	// ---------------- stage 1: operand select and multiply ----------------

	// Read rate and last position of the head item's wheel
	always_comb begin
		rate_rd1 = '0;
		last_rd1 = '0;
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			if (wheel_hit(head_item.wheel, i)) begin
				rate_rd1 = rate_q[i];
				last_rd1 = last_q[i];
			end
		end
	end

	// Position change, zero when the new position is not usable
	assign diff1 = head_item.valid ?
		$signed({head_item.meas[DATA_W-1], head_item.meas}) -
		$signed({last_rd1[DATA_W-1], last_rd1}) : '0;

	always_comb begin
		unique case (head_item.op)
			OP_SIDE: begin
				mul_a1 = $signed({head_item.speed[DATA_W-1], head_item.speed});
				mul_b1 = cfg.inverse_wheel_radius;
			end
			OP_TICK: begin
				mul_a1 = $signed({rate_rd1[DATA_W-1], rate_rd1});
				mul_b1 = cfg.loop_period;
			end
			OP_FEED: begin
				mul_a1 = diff1;
				mul_b1 = cfg.feedback_scale;
			end
			OP_SEED: begin
				mul_a1 = '0;
				mul_b1 = '0;
			end
		endcase
	end

	assign prod1 = mul_a1 * $signed({1'b0, mul_b1});

	// Dead band on the commanded speed magnitude
	assign mag1  = head_item.speed[DATA_W-1] ? DATA_W'(-head_item.speed) : head_item.speed;
	assign live1 = mag1 >= {1'b0, cfg.min_speed};

	// Hold the head item while stage 2 still writes state it reads here
	assign side_off1 = {1'b0, head_item.wheel} - {1'b0, item_s2.wheel};
	assign hazard1 = valid_s2 && (
		(item_s2.op == OP_SIDE && head_item.op == OP_TICK &&
			head_item.wheel >= item_s2.wheel &&
			side_off1 < (WHEEL_W + 1)'(SIDE_WHEELS)) ||
		((item_s2.op == OP_SEED || item_s2.op == OP_FEED) && head_item.op == OP_FEED &&
			head_item.wheel == item_s2.wheel));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (pop) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_s2 <= head_item;
			prod_s2 <= prod1[PROD_W-1:0];
			live_s2 <= live1;
		end
	end

	// ---------------- stage 2: state update ----------------

	// Floor to Q16.16 and saturate
	assign quot2 = prod_s2[PROD_W-1:FRAC_W];
	assign sat2  = sat_q16(PROD_W'(quot2));

	// Clamp the side rate to the allowed magnitude
	always_comb begin
		rlim2 = $signed({{(QUOT_W - CFG_W){1'b0}}, cfg.max_wheel_rate});
		if (quot2 > rlim2) begin
			clamp2 = rlim2;
		end else if (quot2 < -rlim2) begin
			clamp2 = -rlim2;
		end else begin
			clamp2 = quot2;
		end
		side_rate2 = live_s2 ? clamp2[DATA_W-1:0] : '0;
	end

	// Read the stored state of the stage 2 wheel; missing wheels read zero
	always_comb begin
		rate_rd2 = '0;
		tgt_rd2  = '0;
		last_rd2 = '0;
		for (int i = 0; i < WHEEL_COUNT; i++) begin
			if (wheel_hit(item_s2.wheel, i)) begin
				rate_rd2 = rate_q[i];
				tgt_rd2  = target_q[i];
				last_rd2 = last_q[i];
			end
			side_hit2[i] = (32'(item_s2.wheel) <= i) &&
				(i < 32'(item_s2.wheel) + SIDE_WHEELS);
		end
	end

	assign pos2  = item_s2.valid ? item_s2.meas : last_rd2;
	assign seed2 = item_s2.valid ? item_s2.meas : '0;

	// Advance the target and clip the error, keeping its sign
	assign t1_2     = sat_q16(PROD_W'(tgt_rd2) + PROD_W'(sat2));
	assign elim2    = $signed(PROD_W'({1'b0, cfg.error_limit}));
	assign elim_q2  = $signed({1'b0, cfg.error_limit});
	assign hi2      = PROD_W'(pos2) + elim2;
	assign lo2      = PROD_W'(pos2) - elim2;
	assign clip_hi2 = PROD_W'(t1_2) >= hi2;
	assign clip_lo2 = PROD_W'(t1_2) <= lo2;

	always_comb begin
		priority if (clip_hi2) begin
			tick_tgt2 = sat_q16(hi2);
			tick_err2 = elim_q2;
		end else if (clip_lo2) begin
			tick_tgt2 = sat_q16(lo2);
			tick_err2 = -elim_q2;
		end else begin
			tick_tgt2 = t1_2;
			tick_err2 = t1_2 - pos2;
		end
	end

	// Result fields and new state per operation
	always_comb begin
		res2.wheel      = item_s2.wheel;
		res2.target     = tgt_rd2;
		res2.error      = '0;
		res2.rate       = rate_rd2;
		res2.actual     = '0;
		res2.data_valid = item_s2.valid;
		new_tgt2        = tgt_rd2;
		new_last2       = last_rd2;
		unique case (item_s2.op)
			OP_SEED: begin
				new_tgt2    = seed2;
				new_last2   = seed2;
				res2.target = seed2;
			end
			OP_SIDE: begin
				res2.rate       = side_rate2;
				res2.data_valid = 1'b0;
			end
			OP_TICK: begin
				new_tgt2    = tick_tgt2;
				res2.target = tick_tgt2;
				res2.error  = tick_err2;
			end
			OP_FEED: begin
				new_last2   = pos2;
				res2.actual = sat2;
			end
		endcase
	end

	// Write back when the item leaves stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				rate_q[i]   <= '0;
				target_q[i] <= '0;
				last_q[i]   <= '0;
			end
		end else if (s2_move) begin
			for (int i = 0; i < WHEEL_COUNT; i++) begin
				if (item_s2.op == OP_SIDE) begin
					if (side_hit2[i]) begin
						rate_q[i] <= side_rate2;
					end
				end else if (wheel_hit(item_s2.wheel, i)) begin
					target_q[i] <= new_tgt2;
					last_q[i]   <= new_last2;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (s2_move) begin
			valid_s3 <= 1'b1;
		end else if (s3_move) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			res_s3 <= res2;
		end
	end

	// ---------------- stage 3: reported target speed ----------------

	assign prod3  = res_s3.rate * $signed({1'b0, cfg.wheel_radius});
	assign quot3  = prod3[PROD_W-1:FRAC_W];
	assign speed3 = sat_q16(PROD_W'(quot3));

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s3_move) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_move) begin
			out_res_q   <= res_s3;
			out_speed_q <= speed3;
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.wheel_out       = out_res_q.wheel;
	assign out_ch.target_position = out_res_q.target;
	assign out_ch.position_error  = out_res_q.error;
	assign out_ch.wheel_rate      = out_res_q.rate;
	assign out_ch.target_speed    = out_speed_q;
	assign out_ch.actual_speed    = out_res_q.actual;
	assign out_ch.data_valid      = out_res_q.data_valid;

endmodule

// ===== rtl/wheel_position_setpoint_generator.sv =====
// ----------------------------------------------------------------------------
// Wheel position setpoint generator
// Per-wheel rate, target and position bookkeeping for a six-wheel drive.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command item per transfer: seed a wheel, set a side
//   speed, run a control tick on a wheel, or take a feedback sample.
//   out_ch returns one result per item; wheel operations that name a wheel
//   outside the wheel set are taken and give no result.
//   cfg_we/cfg_index/cfg_data write the seven unsigned Q15.16 setup registers while
//   the block is idle.
// Throughput: one item per cycle while out_ch is not stalled. An item waits
//   when it reads state the item just ahead of it is still writing: a tick
//   right after a side command for its side, or a feedback sample right
//   after a seed or sample of the same wheel.
// Path: a result is registered through the queue, the multiply stage, the
//   state update stage and the speed stage to the output register.
// Reset: state and queue clear, registers take their default values.
// When out_ch stalls the output register holds; the pipeline and then the
//   four-entry queue fill before in_ch drops ready.
// ----------------------------------------------------------------------------
module wheel_position_setpoint_generator import wpsg_pkg::*; #(
	parameter int WHEEL_COUNT = WPSG_WHEEL_COUNT,
	parameter int QUEUE_DEPTH = WPSG_QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	wpsg_in_if.sink              in_ch,
	wpsg_out_if.source           out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t  cfg_q;
	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	// Setup register writes; unused indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_SPEED:      cfg_q.min_speed            <= cfg_data;
				REG_INV_RADIUS:     cfg_q.inverse_wheel_radius <= cfg_data;
				REG_MAX_RATE:       cfg_q.max_wheel_rate       <= cfg_data;
				REG_LOOP_PERIOD:    cfg_q.loop_period          <= cfg_data;
				REG_ERROR_LIMIT:    cfg_q.error_limit          <= cfg_data;
				REG_RADIUS:         cfg_q.wheel_radius         <= cfg_data;
				REG_FEEDBACK_SCALE: cfg_q.feedback_scale       <= cfg_data;
				default:            cfg_q                      <= cfg_q;
			endcase
		end
	end

	wpsg_front #(
		.WHEEL_COUNT(WHEEL_COUNT)
	) u_front (
		.in_ch     (in_ch),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	wpsg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	wpsg_back #(
		.WHEEL_COUNT(WHEEL_COUNT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

// ===== rtl/wpsg_checker.sv =====
// ----------------------------------------------------------------------------
// Wheel setpoint port checker
// Watches the channels of the setpoint generator: results only for taken
// items, bounded items in flight, quiet output in reset, stable stalled data.
// ----------------------------------------------------------------------------
module wpsg_checker import wpsg_pkg::*; #(
	parameter int WHEEL_COUNT = WPSG_WHEEL_COUNT,
	parameter int QUEUE_DEPTH = WPSG_QUEUE_DEPTH
) (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         in_operation,
	input logic [WHEEL_W-1:0] in_wheel_index,
	input logic               out_valid,
	input logic               out_ready,
	input logic [WHEEL_W-1:0] out_wheel_out,
	input logic [DATA_W-1:0]  out_target_position,
	input logic [DATA_W-1:0]  out_position_error,
	input logic [DATA_W-1:0]  out_wheel_rate,
	input logic [DATA_W-1:0]  out_target_speed,
	input logic [DATA_W-1:0]  out_actual_speed,
	input logic               out_data_valid
);

	localparam int CNT_W = $clog2(QUEUE_DEPTH + 4);

	logic [CNT_W-1:0] pending_q;
	logic             in_xfer;
	logic             out_xfer;
	logic             makes_result;

	assign makes_result = in_operation == OP_SIDE || 32'(in_wheel_index) < WHEEL_COUNT;
	assign in_xfer      = in_valid && in_ready && makes_result;
	assign out_xfer     = out_valid && out_ready;

	// Count items taken whose result has not been delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (in_xfer && !out_xfer) begin
			pending_q <= pending_q + 1'b1;
		end else if (out_xfer && !in_xfer && pending_q != '0) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_wheel_out) &&
		$stable(out_target_position) && $stable(out_position_error) &&
		$stable(out_wheel_rate) && $stable(out_target_speed) &&
		$stable(out_actual_speed) && $stable(out_data_valid))
		else $error("result changed while stalled");

	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != '0)
		else $error("result without a taken item");

	a_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= CNT_W'(QUEUE_DEPTH + 3))
		else $error("more items in flight than the queue and pipeline hold");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result offered during reset");

endmodule

bind wheel_position_setpoint_generator wpsg_checker #(
	.WHEEL_COUNT(WHEEL_COUNT),
	.QUEUE_DEPTH(QUEUE_DEPTH)
) u_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.in_valid            (in_ch.valid),
	.in_ready            (in_ch.ready),
	.in_operation        (in_ch.operation),
	.in_wheel_index      (in_ch.wheel_index),
	.out_valid           (out_ch.valid),
	.out_ready           (out_ch.ready),
	.out_wheel_out       (out_ch.wheel_out),
	.out_target_position (out_ch.target_position),
	.out_position_error  (out_ch.position_error),
	.out_wheel_rate      (out_ch.wheel_rate),
	.out_target_speed    (out_ch.target_speed),
	.out_actual_speed    (out_ch.actual_speed),
	.out_data_valid      (out_ch.data_valid)
);
